FILE: hw/rtl/lwpc_pkg.sv
`default_nettype none

package lwpc_pkg;

    localparam logic [15:0] CLEAR_COLOR = 16'h8000;
    localparam logic [8:0]  LINE_WIDTH  = 9'd240;
    localparam int          CFG_DATA_W  = 32;
    localparam int          CFG_INDEX_W = 3;

    // Empty priority: no background covers the pixel.
    localparam logic [2:0]  PRIO_NONE   = 3'd4;
    localparam logic [2:0]  PRIO_START  = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIN0_BOUNDS   = 3'd0,
        REG_WIN1_BOUNDS   = 3'd1,
        REG_WIN_ENABLES   = 3'd2,
        REG_WIN_MASKS     = 3'd3,
        REG_LAYER_ENABLES = 3'd4,
        REG_BG_PRIOS      = 3'd5,
        REG_BACKDROP      = 3'd6
    } t_reg_index;

    typedef enum logic [1:0] {
        REGION_WIN0    = 2'd0,
        REGION_WIN1    = 2'd1,
        REGION_SPR_WIN = 2'd2,
        REGION_OUTSIDE = 2'd3
    } t_region;

    typedef struct packed {
        logic [31:0] win0_bounds;
        logic [31:0] win1_bounds;
        logic [2:0]  window_enables;
        logic [19:0] window_layer_masks;
        logic [3:0]  layer_enables;
        logic [7:0]  bg_priorities;
        logic [15:0] fill_color;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  pixel_x;
        logic [7:0]  line_number;
        logic [15:0] bg0_color;
        logic [15:0] bg1_color;
        logic [15:0] bg2_color;
        logic [15:0] bg3_color;
        logic [15:0] sprite_color;
        logic [2:0]  sprite_priority;
        logic        sprite_window_hit;
    } t_pix;

endpackage

`default_nettype wire

FILE: hw/rtl/lwpc_cfg.sv
`default_nettype none

module lwpc_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lwpc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [lwpc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output      lwpc_pkg::t_cfg                      o_cfg
);
    import lwpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_WIN0_BOUNDS:   r_cfg.win0_bounds        <= i_cfg_wdata;
                REG_WIN1_BOUNDS:   r_cfg.win1_bounds        <= i_cfg_wdata;
                REG_WIN_ENABLES:   r_cfg.window_enables     <= i_cfg_wdata[2:0];
                REG_WIN_MASKS:     r_cfg.window_layer_masks <= i_cfg_wdata[19:0];
                REG_LAYER_ENABLES: r_cfg.layer_enables      <= i_cfg_wdata[3:0];
                REG_BG_PRIOS:      r_cfg.bg_priorities      <= i_cfg_wdata[7:0];
                REG_BACKDROP:      r_cfg.fill_color         <= i_cfg_wdata[15:0];
                default: begin
                    // unmapped index: write is dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hw/rtl/lwpc_mix.sv
`default_nettype none

module lwpc_mix #(
    parameter logic [8:0] LINE_WIDTH = lwpc_pkg::LINE_WIDTH
) (
    input  wire lwpc_pkg::t_cfg i_cfg,
    input  wire lwpc_pkg::t_pix i_pix,
    output logic [15:0]         o_final_color
);
    import lwpc_pkg::*;

    function automatic logic win_hit(input logic [31:0] bounds,
                                     input logic [7:0] x,
                                     input logic [7:0] y);
        // half-open box, no wrap: left >= right gives an empty window
        return (x >= bounds[7:0]) && (x < bounds[15:8]) &&
               (y >= bounds[23:16]) && (y < bounds[31:24]);
    endfunction

    t_region     region;
    logic [4:0]  visible;
    logic [15:0] bg_color [4];
    logic [2:0]  best_prio;
    logic [2:0]  prio;
    logic [1:0]  p;
    logic [15:0] color;

    assign bg_color[0] = i_pix.bg0_color;
    assign bg_color[1] = i_pix.bg1_color;
    assign bg_color[2] = i_pix.bg2_color;
    assign bg_color[3] = i_pix.bg3_color;

    always_comb begin
        if (i_cfg.window_enables[0] &&
            win_hit(i_cfg.win0_bounds, i_pix.pixel_x, i_pix.line_number)) begin
            region = REGION_WIN0;
        end else if (i_cfg.window_enables[1] &&
            win_hit(i_cfg.win1_bounds, i_pix.pixel_x, i_pix.line_number)) begin
            region = REGION_WIN1;
        end else if (i_cfg.window_enables[2] && i_pix.sprite_window_hit) begin
            region = REGION_SPR_WIN;
        end else begin
            region = REGION_OUTSIDE;
        end
    end

    always_comb begin
        if (i_cfg.window_enables == 3'd0) begin
            visible = 5'h1F;
        end else begin
            case (region)
                REGION_WIN0:    visible = i_cfg.window_layer_masks[4:0];
                REGION_WIN1:    visible = i_cfg.window_layer_masks[9:5];
                REGION_SPR_WIN: visible = i_cfg.window_layer_masks[14:10];
                default:        visible = i_cfg.window_layer_masks[19:15];
            endcase
        end
    end

    // strict less-than keeps the lower background index on a tie
    always_comb begin
        best_prio = PRIO_START;
        prio      = PRIO_NONE;
        color     = i_cfg.fill_color;
        p         = 2'd0;
        for (int i = 0; i < 4; i++) begin
            p = i_cfg.bg_priorities[2*i +: 2];
            if (i_cfg.layer_enables[i] && visible[i] &&
                (bg_color[i] != CLEAR_COLOR) && ({1'b0, p} < best_prio)) begin
                best_prio = {1'b0, p};
                prio      = {1'b0, p};
                color     = bg_color[i];
            end
        end
        if (visible[4] && (i_pix.sprite_priority <= prio) &&
            (i_pix.sprite_color != CLEAR_COLOR)) begin
            color = i_pix.sprite_color;
        end
        if ({1'b0, i_pix.pixel_x} >= LINE_WIDTH) begin
            color = i_cfg.fill_color;
        end
    end

    assign o_final_color = color;

endmodule

`default_nettype wire

FILE: hw/rtl/layer_window_priority_compositor_core.sv
`default_nettype none

// Layer / window / priority compositor, one screen pixel per transfer.
// Input channel (i_valid / o_ready) carries the pixel column, scanline,
// four background colors, the sprite color and priority, and the sprite
// window flag. Output channel (o_valid / i_ready) carries the final color.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_wdata);
// write it only while no pixel is in flight.
// The input transfer fills the input register; the compose logic reads it
// and the result register captures the color, which drives o_valid.
// Throughput: one pixel per cycle while the receiver takes results; both
// stages are pipeline registers and the compose logic is a single pass
// between them.
// When the receiver stalls, the result register holds its pixel, the input
// register fills with the next one, and o_ready falls once both are full;
// it rises again in the cycle the receiver takes the result.
// Reset (synchronous, active low) empties both stages and clears all
// configuration registers to zero.
module layer_window_priority_compositor_core #(
    parameter logic [8:0] LINE_WIDTH = lwpc_pkg::LINE_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lwpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [lwpc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_valid,
    output      logic                             o_ready,
    input  wire logic [7:0]                       i_pixel_x,
    input  wire logic [7:0]                       i_line_number,
    input  wire logic [15:0]                      i_bg0_color,
    input  wire logic [15:0]                      i_bg1_color,
    input  wire logic [15:0]                      i_bg2_color,
    input  wire logic [15:0]                      i_bg3_color,
    input  wire logic [15:0]                      i_sprite_color,
    input  wire logic [2:0]                       i_sprite_priority,
    input  wire logic                             i_sprite_window_hit,
    output      logic                             o_valid,
    input  wire logic                             i_ready,
    output      logic [15:0]                      o_final_color
);
    import lwpc_pkg::*;

    t_cfg        cfg;
    t_pix        n_pix;
    t_pix        r_pix;
    logic        r_in_valid;
    logic        r_out_valid;
    logic [15:0] n_final_color;
    logic [15:0] r_final_color;
    logic        out_ready;

    lwpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign n_pix = '{
        pixel_x:           i_pixel_x,
        line_number:       i_line_number,
        bg0_color:         i_bg0_color,
        bg1_color:         i_bg1_color,
        bg2_color:         i_bg2_color,
        bg3_color:         i_bg3_color,
        sprite_color:      i_sprite_color,
        sprite_priority:   i_sprite_priority,
        sprite_window_hit: i_sprite_window_hit
    };

    assign out_ready = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pix <= n_pix;
        end
    end

    lwpc_mix #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_mix (
        .i_cfg         (cfg),
        .i_pix         (r_pix),
        .o_final_color (n_final_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && out_ready) begin
            r_final_color <= n_final_color;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_final_color = r_final_color;

endmodule

`default_nettype wire
